// ----- design/pip_pkg.sv -----
// Shared constants and pipeline control types for the point-in-polygon parity block.
package pip_pkg;

  // Default coordinate width: signed Q8.23 fixed point.
  localparam int COORD_WIDTH_DEF = 32;

  // Control bits that travel with each word through the pipeline.
  typedef struct packed {
    logic valid;     // stage holds a word
    logic clr;       // parity restarts (point load or first vertex of a polygon)
    logic emit;      // word is a last vertex and produces a result
    logic main_en;   // edge from the previous vertex straddles the test y
    logic main_pos;  // that edge runs downward (previous y above current y)
    logic close_en;  // closing edge back to the first vertex straddles the test y
    logic close_pos; // closing edge runs downward
  } ctl_t;

endpackage

// ----- design/pip_if.sv -----
// Valid/ready channel interfaces for the vertex input and the inside/outside result.
interface pip_in_if #(parameter int W = pip_pkg::COORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic                kind;
  logic signed [W-1:0] coord_x;
  logic signed [W-1:0] coord_y;
  logic                last;

  modport source (output valid, output kind, output coord_x, output coord_y, output last,
                  input ready);
  modport sink   (input valid, input kind, input coord_x, input coord_y, input last,
                  output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

// ----- design/pip_front.sv -----
// Front stage: polygon state and the coordinate differences for both edges of a word.
module pip_front #(
  parameter int W = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                acc,
  input  logic                kind,
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] y,
  input  logic                last,
  output pip_pkg::ctl_t       ctl_r,
  output logic signed [W:0]   ma_r,
  output logic signed [W:0]   mb_r,
  output logic signed [W:0]   mc_r,
  output logic signed [W:0]   md_r,
  output logic signed [W:0]   ca_r,
  output logic signed [W:0]   cb_r,
  output logic signed [W:0]   cc_r,
  output logic signed [W:0]   cd_r
);
  import pip_pkg::*;

  logic signed [W-1:0] point_x_r, point_y_r;
  logic signed [W-1:0] first_x_r, first_y_r;
  logic signed [W-1:0] prev_x_r, prev_y_r;
  logic                in_poly_r;

  logic signed [W-1:0] fsel_x, fsel_y;
  logic signed [W:0]   xe, ye, pxe, pye, vxe, vye, fxe, fye;
  logic signed [W:0]   ma_nxt, mb_nxt, mc_nxt, md_nxt;
  logic signed [W:0]   ca_nxt, cb_nxt, cc_nxt, cd_nxt;
  logic                gt_cur, gt_prev, gt_first;
  ctl_t                ctl_nxt;

  // With no polygon open the current vertex is also the first one.
  assign fsel_x = in_poly_r ? first_x_r : x;
  assign fsel_y = in_poly_r ? first_y_r : y;

  assign xe  = {x[W-1], x};
  assign ye  = {y[W-1], y};
  assign pxe = {point_x_r[W-1], point_x_r};
  assign pye = {point_y_r[W-1], point_y_r};
  assign vxe = {prev_x_r[W-1], prev_x_r};
  assign vye = {prev_y_r[W-1], prev_y_r};
  assign fxe = {fsel_x[W-1], fsel_x};
  assign fye = {fsel_y[W-1], fsel_y};

  assign gt_cur   = y > point_y_r;
  assign gt_prev  = prev_y_r > point_y_r;
  assign gt_first = fsel_y > point_y_r;

  // Edge from the previous vertex to the current one.
  assign ma_nxt = pxe - xe;
  assign mb_nxt = vye - ye;
  assign mc_nxt = vxe - xe;
  assign md_nxt = pye - ye;
  // Closing edge from the current vertex back to the first one.
  assign ca_nxt = pxe - fxe;
  assign cb_nxt = ye - fye;
  assign cc_nxt = xe - fxe;
  assign cd_nxt = pye - fye;

  always_comb begin
    ctl_nxt           = '0;
    ctl_nxt.valid     = acc;
    ctl_nxt.clr       = !kind || !in_poly_r;
    ctl_nxt.emit      = kind && last;
    ctl_nxt.main_en   = kind && in_poly_r && (gt_cur != gt_prev);
    ctl_nxt.main_pos  = !mb_nxt[W];
    ctl_nxt.close_en  = kind && last && (gt_cur != gt_first);
    ctl_nxt.close_pos = !cb_nxt[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= '0;
      point_x_r <= '0;
      point_y_r <= '0;
      in_poly_r <= 1'b0;
    end else begin
      if (en) begin
        ctl_r <= ctl_nxt;
      end
      if (acc) begin
        if (!kind) begin
          point_x_r <= x;
          point_y_r <= y;
          in_poly_r <= 1'b0;
        end else begin
          in_poly_r <= !last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && kind) begin
      if (!in_poly_r) begin
        first_x_r <= x;
        first_y_r <= y;
      end
      prev_x_r <= x;
      prev_y_r <= y;
    end
    if (en) begin
      ma_r <= ma_nxt;
      mb_r <= mb_nxt;
      mc_r <= mc_nxt;
      md_r <= md_nxt;
      ca_r <= ca_nxt;
      cb_r <= cb_nxt;
      cc_r <= cc_nxt;
      cd_r <= cd_nxt;
    end
  end

endmodule

// ----- design/pip_edge_mul.sv -----
// Multiply stage for one edge: both cross products of the crossing test, registered.
module pip_edge_mul #(
  parameter int W = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W:0]     a,
  input  logic signed [W:0]     b,
  input  logic signed [W:0]     c,
  input  logic signed [W:0]     d,
  output logic signed [2*W+1:0] lhs_r,
  output logic signed [2*W+1:0] rhs_r
);
  import pip_pkg::*;

  logic signed [2*W+1:0] lhs_nxt, rhs_nxt;

  // lhs is (px - xi) * (yj - yi), rhs is (xj - xi) * (py - yi).
  assign lhs_nxt = a * b;
  assign rhs_nxt = c * d;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_r <= lhs_nxt;
      rhs_r <= rhs_nxt;
    end
  end

endmodule

// ----- design/pip_parity.sv -----
// Compare stage: crossing decisions, the running parity and the result register.
module pip_parity #(
  parameter int W = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pip_pkg::ctl_t         ctl,
  input  logic signed [2*W+1:0] main_lhs,
  input  logic signed [2*W+1:0] main_rhs,
  input  logic signed [2*W+1:0] close_lhs,
  input  logic signed [2*W+1:0] close_rhs,
  input  logic                  out_ready,
  output logic                  out_valid_r,
  output logic                  inside_r
);
  import pip_pkg::*;

  logic parity_r, parity_nxt;
  logic hit_main, hit_close, par_base, par_new;

  // A downward edge crosses when lhs < rhs, an upward one when lhs > rhs.
  assign hit_main  = ctl.main_en &&
                     (ctl.main_pos ? (main_lhs < main_rhs) : (main_lhs > main_rhs));
  assign hit_close = ctl.close_en &&
                     (ctl.close_pos ? (close_lhs < close_rhs) : (close_lhs > close_rhs));

  assign par_base   = ctl.clr ? 1'b0 : parity_r;
  assign par_new    = par_base ^ hit_main ^ hit_close;
  assign parity_nxt = ctl.emit ? 1'b0 : par_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en && ctl.valid) begin
        parity_r <= parity_nxt;
      end
      if (en && ctl.valid && ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl.valid && ctl.emit) begin
      inside_r <= par_new;
    end
  end

endmodule

// ----- design/point_in_polygon_parity.sv -----
// Top level of the even-odd ray-crossing point-in-polygon tester.
//
// Usage: words arrive on in_ch. A word with kind 0 loads the test point and
// abandons any polygon in progress. Words with kind 1 are polygon vertices in
// order; the vertex with last set closes the polygon, and one word with
// inside_res (1 = inside, 0 = outside) then appears on out_ch. Later vertices
// start a new polygon against the same test point. Before any point load the
// test point is the origin. A polygon of one vertex reports outside.
//
// Pipeline: one word is taken every cycle while the pipeline is not halted.
// For a last vertex, the differences are registered when the word is accepted,
// the multiply stage then registers the products of two 33x33 multipliers per
// edge (four in all, one pair for the edge to the previous vertex and one for
// the closing edge), and the compare stage loads the result into the output register.
//
// Reset (rst_n low, synchronous) clears the test point, the open polygon, the
// parity and all pipeline valid bits. When the receiver stalls, words that
// make no result keep flowing; the pipeline halts only while a result waits
// in the output register and the next result stands right behind it.
module point_in_polygon_parity #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pip_in_if.sink   in_ch,
  pip_out_if.source out_ch
);
  import pip_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                  en, acc;
  ctl_t                  ctl1_r, ctl2_r;
  logic signed [W:0]     ma_r, mb_r, mc_r, md_r, ca_r, cb_r, cc_r, cd_r;
  logic signed [2*W+1:0] main_lhs_r, main_rhs_r, close_lhs_r, close_rhs_r;
  logic                  out_valid_r, inside_r;

  // The pipeline advances unless a result is held in the output register
  // and the word at the compare stage would produce another one.
  assign en  = !out_valid_r || out_ch.ready || !(ctl2_r.valid && ctl2_r.emit);
  assign acc = in_ch.valid && en;

  assign in_ch.ready       = en;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = inside_r;

  pip_front #(.W(W)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .acc   (acc),
    .kind  (in_ch.kind),
    .x     (in_ch.coord_x),
    .y     (in_ch.coord_y),
    .last  (in_ch.last),
    .ctl_r (ctl1_r),
    .ma_r  (ma_r),
    .mb_r  (mb_r),
    .mc_r  (mc_r),
    .md_r  (md_r),
    .ca_r  (ca_r),
    .cb_r  (cb_r),
    .cc_r  (cc_r),
    .cd_r  (cd_r)
  );

  // Edge from the previous vertex to the current one.
  pip_edge_mul #(.W(W)) u_mul_main (
    .clk   (clk),
    .en    (en),
    .a     (ma_r),
    .b     (mb_r),
    .c     (mc_r),
    .d     (md_r),
    .lhs_r (main_lhs_r),
    .rhs_r (main_rhs_r)
  );

  // Closing edge from the last vertex back to the first.
  pip_edge_mul #(.W(W)) u_mul_close (
    .clk   (clk),
    .en    (en),
    .a     (ca_r),
    .b     (cb_r),
    .c     (cc_r),
    .d     (cd_r),
    .lhs_r (close_lhs_r),
    .rhs_r (close_rhs_r)
  );

  // Control bits follow the products through the multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
  end

  pip_parity #(.W(W)) u_parity (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl         (ctl2_r),
    .main_lhs    (main_lhs_r),
    .main_rhs    (main_rhs_r),
    .close_lhs   (close_lhs_r),
    .close_rhs   (close_rhs_r),
    .out_ready   (out_ch.ready),
    .out_valid_r (out_valid_r),
    .inside_r    (inside_r)
  );

endmodule

// ----- design/pip_checker.sv -----
// Port-level checker for the point-in-polygon parity block, bound to the top level.
module pip_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside
);
  import pip_pkg::*;

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside))
    else $error("result word changed while stalled");

  // The input side is never blocked while the output side can drain.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with a free output");

  // No result comes out of reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

  // A new result is only loaded while the pipeline advances.
  a_load_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result loaded while pipeline halted");

endmodule

bind point_in_polygon_parity pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_inside (out_ch.inside_res)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the even-odd point-in-polygon parity block.
module tb_top;

  import pip_pkg::*;

  localparam int COORD_WIDTH = COORD_WIDTH_DEF;

  // Word kinds on the input channel.
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // The run ends after this many time units even if results are still missing.
  localparam int RUN_LIMIT = 5_000_000;

  // How the generator places coordinates: close to the test point (many straddles,
  // ties and horizontal edges), anywhere in the range, or on the range corners.
  typedef enum int {
    CM_NEAR,
    CM_WIDE,
    CM_CORNER
  } coord_mode_e;

  typedef struct {
    logic                          kind;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          last;
  } word_t;

  logic clk;
  logic rst_n;

  pip_in_if #(.W(COORD_WIDTH)) in_ch ();
  pip_out_if                   out_ch ();

  point_in_polygon_parity #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Words waiting to be sent, and the inside/outside answers still owed by the block.
  word_t pending_words[$];
  bit    inside_q[$];

  int mismatches = 0;
  int send_idle  = 0;  // percent of cycles the sender holds back
  int recv_idle  = 0;  // percent of cycles the receiver stalls

  // Generator's notion of the current test point, used to aim nearby vertices.
  logic signed [COORD_WIDTH-1:0] aim_x = '0;
  logic signed [COORD_WIDTH-1:0] aim_y = '0;

  // Shadow state of the block, kept sign-extended so that differences never wrap.
  longint pt_x, pt_y;
  longint first_x, first_y;
  longint prev_x, prev_y;
  bit     parity_acc;
  bit     poly_open;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // True when the edge from (xj,yj) to (xi,yi) crosses the rightward ray from the
  // test point. The crossing x is never divided out: both sides of the comparison
  // are scaled by dy, and the sense of the compare flips when dy is negative.
  function automatic bit side_crosses(input longint xj, input longint yj,
                                      input longint xi, input longint yi);
    longint                dy;
    logic signed [127:0]   lhs;
    logic signed [127:0]   rhs;
    if ((yi > pt_y) == (yj > pt_y)) return 1'b0;
    dy  = yj - yi;
    lhs = (pt_x - xi) * dy;
    rhs = (xj - xi) * (pt_y - yi);
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // Advances the shadow state by one accepted word and queues the answer that a
  // last vertex owes.
  task automatic track_polygon(input logic kind, input logic signed [COORD_WIDTH-1:0] x,
                               input logic signed [COORD_WIDTH-1:0] y, input logic last);
    longint cx;
    longint cy;
    cx = longint'(x);
    cy = longint'(y);
    if (kind == KIND_POINT) begin
      // A point load drops any open polygon; its last flag means nothing.
      pt_x       = cx;
      pt_y       = cy;
      parity_acc = 1'b0;
      poly_open  = 1'b0;
      return;
    end
    if (!poly_open) begin
      first_x    = cx;
      first_y    = cy;
      parity_acc = 1'b0;
      poly_open  = 1'b1;
    end else begin
      parity_acc ^= side_crosses(prev_x, prev_y, cx, cy);
    end
    prev_x = cx;
    prev_y = cy;
    if (last) begin
      // Closing edge back to the first vertex; for one vertex it is a point and
      // never straddles, so the answer is outside.
      parity_acc ^= side_crosses(cx, cy, first_x, first_y);
      inside_q.push_back(parity_acc);
      parity_acc = 1'b0;
      poly_open  = 1'b0;
    end
  endtask

  task automatic push_word(input logic kind, input logic signed [COORD_WIDTH-1:0] x,
                           input logic signed [COORD_WIDTH-1:0] y, input logic last);
    word_t w;
    w.kind = kind;
    w.x    = x;
    w.y    = y;
    w.last = last;
    pending_words.push_back(w);
    if (kind == KIND_POINT) begin
      aim_x = x;
      aim_y = y;
    end
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord(
      input coord_mode_e mode, input logic signed [COORD_WIDTH-1:0] center,
      input int unsigned scale_sh);
    logic signed [COORD_WIDTH-1:0] offs;
    case (mode)
      CM_NEAR: begin
        offs = $signed($urandom_range(0, 8)) - 4;
        return center + (offs <<< scale_sh);
      end
      CM_WIDE: begin
        return $urandom;
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
          1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
          2:       return '0;
          3:       return '1;
          4:       return 1;
          default: return {1'b1, {(COORD_WIDTH-2){1'b0}}, 1'b1};
        endcase
      end
    endcase
  endfunction

  function automatic coord_mode_e pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return CM_NEAR;
    if (r < 8) return CM_WIDE;
    return CM_CORNER;
  endfunction

  // Mostly well-formed polygons with random content; now and then a point load
  // breaks a polygon midway, which the block must treat as an abandon.
  task automatic fill_random(input int target);
    int            made;
    int            n_vert;
    int unsigned   sh;
    coord_mode_e   mode;
    made = 0;
    while (made < target) begin
      if (made == 0 || $urandom_range(0, 3) == 0) begin
        mode = pick_mode();
        push_word(KIND_POINT, pick_coord(mode, aim_x, $urandom_range(0, 24)),
                  pick_coord(mode, aim_y, $urandom_range(0, 24)), 1'($urandom));
        made++;
      end
      n_vert = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      mode   = pick_mode();
      sh     = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 26);
      for (int k = 0; k < n_vert; k++) begin
        push_word(KIND_VERTEX, pick_coord(mode, aim_x, sh), pick_coord(mode, aim_y, sh),
                  (k == n_vert - 1));
        if (k < n_vert - 1 && $urandom_range(0, 39) == 0) begin
          push_word(KIND_POINT, pick_coord(mode, aim_x, sh), pick_coord(mode, aim_y, sh),
                    1'($urandom));
          made++;
        end
      end
      made += n_vert;
    end
  endtask

  // Blocks until every queued word has been taken and every answer has come back,
  // then lets the pipeline settle.
  task automatic drain_all();
    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (inside_q.size() == 0);
    repeat (6) @(negedge clk);
  endtask

  // Driver: a new word is presented only when the current one was taken (or none
  // is up), so valid is never dropped under a waiting word.
  word_t drv_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        drv_word       = pending_words.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= drv_word.kind;
        in_ch.coord_x <= drv_word.x;
        in_ch.coord_y <= drv_word.y;
        in_ch.last    <= drv_word.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Every word the block takes updates the shadow state at the same edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      track_polygon(in_ch.kind, in_ch.coord_x, in_ch.coord_y, in_ch.last);
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Result monitor: each answer taken is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (inside_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result inside_res=%0b", out_ch.inside_res));
      end else if (out_ch.inside_res !== inside_q[0]) begin
        report_mismatch($sformatf("inside_res=%0b, expected %0b", out_ch.inside_res,
                                  inside_q[0]));
        void'(inside_q.pop_front());
      end else begin
        void'(inside_q.pop_front());
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL point_in_polygon_parity");
    $finish;
  end

  initial begin
    logic signed [COORD_WIDTH-1:0] c_min;
    logic signed [COORD_WIDTH-1:0] c_max;
    c_min = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    c_max = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_POINT;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    pt_x          = 0;
    pt_y          = 0;
    first_x       = 0;
    first_y       = 0;
    prev_x        = 0;
    prev_y        = 0;
    parity_acc    = 1'b0;
    poly_open     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: the sender is mostly busy, the receiver stalls heavily.
    send_idle = 36;
    recv_idle = 86;

    // Directed part. Before any point load the test point is the origin: a lone
    // vertex reports outside, and a triangle around the origin reports inside.
    push_word(KIND_VERTEX, 5, 5, 1'b1);
    push_word(KIND_VERTEX, -10, -10, 1'b0);
    push_word(KIND_VERTEX, 10, -10, 1'b0);
    push_word(KIND_VERTEX, 0, 10, 1'b1);
    // A point load with its last flag set; the flag must be ignored.
    push_word(KIND_POINT, 0, 0, 1'b1);
    // Square with two horizontal edges, one of them at the test y.
    push_word(KIND_VERTEX, -4, 0, 1'b0);
    push_word(KIND_VERTEX, 4, 0, 1'b0);
    push_word(KIND_VERTEX, 4, 4, 1'b0);
    push_word(KIND_VERTEX, -4, 4, 1'b1);
    // A polygon abandoned by a point load at the range corner, then a lone vertex.
    push_word(KIND_VERTEX, 1, 1, 1'b0);
    push_word(KIND_VERTEX, 2, -2, 1'b0);
    push_word(KIND_POINT, c_min, c_max, 1'b0);
    push_word(KIND_VERTEX, c_max, c_max, 1'b1);
    // Full-range edges, where the differences need every bit of the products.
    push_word(KIND_POINT, 0, 0, 1'b0);
    push_word(KIND_VERTEX, c_min, c_min, 1'b0);
    push_word(KIND_VERTEX, c_max, c_min, 1'b0);
    push_word(KIND_VERTEX, c_max, c_max, 1'b0);
    push_word(KIND_VERTEX, c_min, c_max, 1'b1);
    push_word(KIND_POINT, c_max, -1, 1'b0);
    push_word(KIND_VERTEX, c_min, c_max, 1'b0);
    push_word(KIND_VERTEX, c_max, c_min, 1'b1);
    // Vertices lying exactly on the test y and the test point on an edge.
    push_word(KIND_POINT, 3, 3, 1'b0);
    push_word(KIND_VERTEX, 3, 0, 1'b0);
    push_word(KIND_VERTEX, 3, 6, 1'b0);
    push_word(KIND_VERTEX, 0, 3, 1'b1);

    fill_random(600);
    // The sender pauses here until every answer owed so far is back.
    drain_all();

    // Phase two: roles swapped.
    send_idle = 86;
    recv_idle = 36;
    fill_random(600);
    drain_all();

    // Phase three: full throughput on both sides.
    send_idle = 0;
    recv_idle = 0;
    fill_random(650);
    drain_all();

    if (mismatches == 0) begin
      $display("PASS point_in_polygon_parity");
    end else begin
      $display("FAIL point_in_polygon_parity");
    end
    $finish;
  end

endmodule
